FILE: hdl/hat_direction_from_buttons_core_macros.svh
// ---------------------------------------------------------------------------
// Hat direction core assertion macros
// Concurrent assertion wrappers that compile to nothing under synthesis.
// ---------------------------------------------------------------------------
`ifndef HAT_DIRECTION_FROM_BUTTONS_CORE_MACROS_SVH
`define HAT_DIRECTION_FROM_BUTTONS_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define HDFB_ASSERT_IMP(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("hdfb assertion failed");
`define HDFB_ASSERT_NXT(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("hdfb assertion failed");
`else
`define HDFB_ASSERT_IMP(label, clk_s, rstn_s, ante, cons)
`define HDFB_ASSERT_NXT(label, clk_s, rstn_s, ante, cons)
`endif
`endif

FILE: hdl/hdfb_pkg.sv
// ---------------------------------------------------------------------------
// Hat direction core package
// Shared widths, angle constants, the arctangent table and interface types.
// ---------------------------------------------------------------------------
package hdfb_pkg;

    localparam int MAX_INPUTS        = 8;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int BTN_W      = 8;
    localparam int BTN_IDX_W  = 3;
    localparam int CNT_W      = 4;
    localparam int HAT_W      = 2;
    localparam int DIR_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam int N_CAP = (MAX_INPUTS < 15) ? MAX_INPUTS : 15;

    localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMBINE_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HAT_INDEX    = 2'd2;

    localparam logic [CNT_W-1:0] INPUT_COUNT_RST = 4'd8;

    localparam logic signed [DIR_W-1:0] DIR_NONE = -10'sd1;
    localparam logic signed [DIR_W-1:0] DIR_INIT = -10'sd2;

    // Angles are signed Q.20 degrees.
    localparam int ANG_W = 31;
    localparam logic signed [ANG_W-1:0] ANG_90   = ANG_W'(94371840);
    localparam logic signed [ANG_W-1:0] ANG_180  = ANG_W'(188743680);
    localparam logic signed [ANG_W-1:0] ANG_360  = ANG_W'(377487360);
    localparam logic signed [ANG_W-1:0] HALF_DEG = ANG_W'(524288);

    localparam int DEG_W = 9;
    localparam logic [DIR_W-1:0] DEG_FULL = 10'd360;

    localparam int TABLE_LEN  = 24;
    localparam int ATAN_IDX_W = 5;
    localparam int ATAN_W     = 27;
    localparam logic [ATAN_W-1:0] ATAN_Q20 [TABLE_LEN] = '{
        27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121,
        27'd3750058,  27'd1876857,  27'd938658,   27'd469357,
        27'd234682,   27'd117342,   27'd58671,    27'd29335,
        27'd14668,    27'd7334,     27'd3667,     27'd1833,
        27'd917,      27'd458,      27'd229,      27'd115,
        27'd57,       27'd29,       27'd14,       27'd7
    };

    localparam int ROT_W = 26;
    localparam int Q14_W = 16;
    localparam int SUM_W = 19;
    localparam int VEC_W = SUM_W + 10;

    localparam int QUEUE_DEPTH = 2;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_NONE    = 2'd0;
    localparam kind_t KIND_FIRST   = 2'd1;
    localparam kind_t KIND_COMBINE = 2'd2;

    typedef struct packed {
        kind_t                kind;
        logic [BTN_IDX_W-1:0] first;
        logic [BTN_W-1:0]     mask;
    } item_t;

    typedef struct packed {
        logic [DEG_W-1:0]        deg;
        logic signed [Q14_W-1:0] cx;
        logic signed [Q14_W-1:0] cy;
    } entry_t;

    typedef struct packed {
        logic [CNT_W-1:0] n_eff;
        logic             combine;
    } cfg_t;

endpackage

FILE: hdl/hdfb_front.sv
// ---------------------------------------------------------------------------
// Hat direction front end
// Accepts button snapshots, masks unused buttons and classifies each item.
// ---------------------------------------------------------------------------
module hdfb_front (
    input  logic                        push,
    output logic                        full,
    input  logic [hdfb_pkg::BTN_W-1:0]  buttons,
    input  hdfb_pkg::cfg_t              cfg,
    input  logic                        table_ready,
    input  logic                        q_full,
    output logic                        q_write,
    output hdfb_pkg::item_t             q_item
);
    import hdfb_pkg::*;

    logic [BTN_W-1:0]     mask;
    logic [BTN_IDX_W-1:0] first;
    logic                 single;

    always_comb
    begin
        for (int i = 0; i < BTN_W; i++)
        begin
            mask[i] = buttons[i] && (CNT_W'(i) < cfg.n_eff);
        end
        first = '0;
        for (int i = BTN_W - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                first = BTN_IDX_W'(i);
            end
        end
        single = (mask & (mask - 1'b1)) == '0;
    end

    always_comb
    begin
        q_item.first = first;
        q_item.mask  = mask;
        if (mask == '0)
        begin
            q_item.kind = KIND_NONE;
        end
        else if (!cfg.combine || single)
        begin
            q_item.kind = KIND_FIRST;
        end
        else
        begin
            q_item.kind = KIND_COMBINE;
        end
    end

    assign full    = !table_ready || q_full;
    assign q_write = push && !full;

endmodule

FILE: hdl/hdfb_queue.sv
// ---------------------------------------------------------------------------
// Hat direction item queue
// Short queue of classified items between the front end and the back end.
// ---------------------------------------------------------------------------
module hdfb_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            write,
    input  hdfb_pkg::item_t wr_item,
    output logic            q_full,
    input  logic            read,
    output hdfb_pkg::item_t rd_item,
    output logic            q_empty
);
    import hdfb_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    logic             do_write;
    logic             do_read;

    assign q_full   = count_reg == (PTR_W+1)'(QUEUE_DEPTH);
    assign q_empty  = count_reg == '0;
    assign do_write = write && !q_full;
    assign do_read  = read && !q_empty;
    assign rd_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_write ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_read ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_write && !do_read)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_read && !do_write)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

FILE: hdl/hdfb_setup.sv
// ---------------------------------------------------------------------------
// Hat direction angle table builder
// Builds per button the rounded angle and the Q.14 unit vector, using a
// serial divider and a rotation CORDIC, after reset and each count change.
// ---------------------------------------------------------------------------
module hdfb_setup #(
    parameter int CORDIC_STAGES = hdfb_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rebuild,
    input  logic [hdfb_pkg::CNT_W-1:0]    n_eff,
    output logic                          table_ready,
    input  logic [hdfb_pkg::BTN_IDX_W-1:0] rd_addr,
    output hdfb_pkg::entry_t              rd_entry
);
    import hdfb_pkg::*;

    localparam int SW        = $clog2(CORDIC_STAGES);
    localparam int DVD_W     = 33;
    localparam int QUO_W     = 29;
    localparam int REM_W     = 5;
    localparam int DIV_CNT_W = $clog2(DVD_W);

    localparam logic [DVD_W-1:0] TWO_K = DVD_W'(754974720);
    localparam logic signed [ROT_W-1:0] INV_GAIN  = 26'sd2546996;
    localparam logic signed [ROT_W-1:0] ROUND_Q14 = 26'sd128;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_PRE   = 3'd3;
    localparam logic [2:0] S_ROT   = 3'd4;
    localparam logic [2:0] S_STORE = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic                   ready_reg, ready_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [SW-1:0]          rot_cnt_reg, rot_cnt_next;
    logic [DVD_W-1:0]       base_reg, base_next;
    logic [DVD_W-1:0]       dvd_reg, dvd_next;
    logic [QUO_W-1:0]       quo_reg, quo_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic signed [ROT_W-1:0] x_reg, x_next;
    logic signed [ROT_W-1:0] y_reg, y_next;
    logic signed [ANG_W-1:0] z_reg, z_next;
    entry_t                 tbl_reg [BTN_W];

    logic [CNT_W-1:0]       lim;
    logic [REM_W-1:0]       divisor;
    logic [REM_W:0]         trial;
    logic                   ge;
    logic signed [ANG_W-1:0] theta;
    logic signed [ANG_W-1:0] theta_w;
    logic signed [ANG_W-1:0] atan_s;
    logic signed [ROT_W-1:0] sh_x;
    logic signed [ROT_W-1:0] sh_y;
    logic [QUO_W:0]         deg_sum;
    logic [DIR_W-1:0]       deg_raw;
    entry_t                 entry_new;
    logic                   tbl_write;

    assign lim     = (n_eff > CNT_W'(BTN_W)) ? CNT_W'(BTN_W) : n_eff;
    assign divisor = {n_eff, 1'b0};
    assign trial   = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge      = trial >= {1'b0, divisor};
    assign theta   = signed'(ANG_W'(quo_reg));
    assign theta_w = (theta >= ANG_180) ? theta - ANG_360 : theta;
    assign atan_s  = signed'(ANG_W'(ATAN_Q20[ATAN_IDX_W'(rot_cnt_reg)]));
    assign sh_x    = x_reg >>> rot_cnt_reg;
    assign sh_y    = y_reg >>> rot_cnt_reg;
    assign deg_sum = {1'b0, quo_reg} + (QUO_W+1)'(HALF_DEG);
    assign deg_raw = deg_sum[QUO_W:20];

    always_comb
    begin
        entry_new.cx  = Q14_W'((x_reg + ROUND_Q14) >>> 8);
        entry_new.cy  = Q14_W'((y_reg + ROUND_Q14) >>> 8);
        entry_new.deg = (deg_raw == DEG_FULL) ? '0 : deg_raw[DEG_W-1:0];
    end

    always_comb
    begin
        state_next   = state_reg;
        ready_next   = ready_reg;
        idx_next     = idx_reg;
        div_cnt_next = div_cnt_reg;
        rot_cnt_next = rot_cnt_reg;
        base_next    = base_reg;
        dvd_next     = dvd_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        tbl_write    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_START:
            begin
                idx_next  = '0;
                base_next = '0;
                if (lim == '0)
                begin
                    ready_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    dvd_next     = DVD_W'(n_eff);
                    rem_next     = '0;
                    quo_next     = '0;
                    div_cnt_next = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next     = ge ? REM_W'(trial - {1'b0, divisor}) : REM_W'(trial);
                quo_next     = {quo_reg[QUO_W-2:0], ge};
                dvd_next     = {dvd_reg[DVD_W-2:0], 1'b0};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DVD_W - 1))
                begin
                    state_next = S_PRE;
                end
            end
            S_PRE:
            begin
                if (theta_w > ANG_90)
                begin
                    x_next = '0;
                    y_next = INV_GAIN;
                    z_next = theta_w - ANG_90;
                end
                else if (theta_w < -ANG_90)
                begin
                    x_next = '0;
                    y_next = -INV_GAIN;
                    z_next = theta_w + ANG_90;
                end
                else
                begin
                    x_next = INV_GAIN;
                    y_next = '0;
                    z_next = theta_w;
                end
                rot_cnt_next = '0;
                state_next   = S_ROT;
            end
            S_ROT:
            begin
                if (!z_reg[ANG_W-1])
                begin
                    x_next = x_reg - sh_y;
                    y_next = y_reg + sh_x;
                    z_next = z_reg - atan_s;
                end
                else
                begin
                    x_next = x_reg + sh_y;
                    y_next = y_reg - sh_x;
                    z_next = z_reg + atan_s;
                end
                rot_cnt_next = rot_cnt_reg + 1'b1;
                if (rot_cnt_reg == SW'(CORDIC_STAGES - 1))
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                tbl_write = 1'b1;
                idx_next  = idx_reg + 1'b1;
                if (idx_next == lim)
                begin
                    ready_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    base_next    = base_reg + TWO_K;
                    dvd_next     = base_reg + TWO_K + DVD_W'(n_eff);
                    rem_next     = '0;
                    quo_next     = '0;
                    div_cnt_next = '0;
                    state_next   = S_DIV;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (rebuild)
        begin
            state_next = S_START;
            ready_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_START;
            ready_reg   <= 1'b0;
            idx_reg     <= '0;
            div_cnt_reg <= '0;
            rot_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ready_reg   <= ready_next;
            idx_reg     <= idx_next;
            div_cnt_reg <= div_cnt_next;
            rot_cnt_reg <= rot_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        dvd_reg  <= dvd_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        if (tbl_write)
        begin
            tbl_reg[idx_reg[BTN_IDX_W-1:0]] <= entry_new;
        end
    end

    assign table_ready = ready_reg;
    assign rd_entry    = tbl_reg[rd_addr];

endmodule

FILE: hdl/hdfb_back.sv
// ---------------------------------------------------------------------------
// Hat direction back end
// Sums unit vectors, runs the vectoring CORDIC, suppresses repeated
// directions and holds the result register.
// ---------------------------------------------------------------------------
`include "hat_direction_from_buttons_core_macros.svh"

module hdfb_back #(
    parameter int CORDIC_STAGES = hdfb_pkg::CORDIC_STAGES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_empty,
    input  hdfb_pkg::item_t                    q_item,
    output logic                               q_read,
    output logic [hdfb_pkg::BTN_IDX_W-1:0]     rd_addr,
    input  hdfb_pkg::entry_t                   rd_entry,
    input  logic [hdfb_pkg::HAT_W-1:0]         hat,
    output logic                               empty,
    input  logic                               pop,
    output logic [hdfb_pkg::HAT_W-1:0]         hat_select,
    output logic signed [hdfb_pkg::DIR_W-1:0]  direction
);
    import hdfb_pkg::*;

    localparam int SW = $clog2(CORDIC_STAGES);

    localparam logic signed [SUM_W-1:0] SUM_LIM = 19'sd2;

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_SUM   = 3'd1;
    localparam logic [2:0] B_PREP  = 3'd2;
    localparam logic [2:0] B_VEC   = 3'd3;
    localparam logic [2:0] B_WRAP  = 3'd4;
    localparam logic [2:0] B_ROUND = 3'd5;
    localparam logic [2:0] B_EMIT  = 3'd6;

    logic [2:0]              state_reg, state_next;
    logic [SW-1:0]           cnt_reg, cnt_next;
    logic [BTN_W-1:0]        mask_reg, mask_next;
    logic signed [SUM_W-1:0] sx_reg, sx_next;
    logic signed [SUM_W-1:0] sy_reg, sy_next;
    logic signed [VEC_W-1:0] x_reg, x_next;
    logic signed [VEC_W-1:0] y_reg, y_next;
    logic signed [ANG_W-1:0] z_reg, z_next;
    logic signed [DIR_W-1:0] dir_reg, dir_next;
    logic signed [DIR_W-1:0] last_reg, last_next;
    logic                    out_valid_reg, out_valid_next;
    logic [HAT_W-1:0]        out_hat_reg;
    logic signed [DIR_W-1:0] out_dir_reg;

    logic                    out_load;
    logic                    cancel;
    logic signed [VEC_W-1:0] sxs;
    logic signed [VEC_W-1:0] sys;
    logic signed [VEC_W-1:0] sh_x;
    logic signed [VEC_W-1:0] sh_y;
    logic signed [ANG_W-1:0] atan_s;
    logic signed [ANG_W-1:0] z_wrap;
    logic signed [ANG_W-1:0] z_half;
    logic [DIR_W-1:0]        deg_raw;

    assign rd_addr = (state_reg == B_IDLE) ? q_item.first : cnt_reg[BTN_IDX_W-1:0];
    assign cancel  = (sx_reg > -SUM_LIM) && (sx_reg < SUM_LIM)
                     && (sy_reg > -SUM_LIM) && (sy_reg < SUM_LIM);
    assign sxs     = VEC_W'(signed'({sx_reg, 8'b0}));
    assign sys     = VEC_W'(signed'({sy_reg, 8'b0}));
    assign sh_x    = x_reg >>> cnt_reg;
    assign sh_y    = y_reg >>> cnt_reg;
    assign atan_s  = signed'(ANG_W'(ATAN_Q20[ATAN_IDX_W'(cnt_reg)]));
    assign z_wrap  = z_reg + ANG_360;
    assign z_half  = z_reg + HALF_DEG;
    assign deg_raw = z_half[29:20];
    assign out_load = (state_reg == B_EMIT) && (dir_reg != last_reg)
                      && (!out_valid_reg || pop);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mask_next  = mask_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        dir_next   = dir_reg;
        last_next  = last_reg;
        q_read     = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_read = 1'b1;
                    unique case (q_item.kind)
                        KIND_FIRST:
                        begin
                            dir_next   = signed'({1'b0, rd_entry.deg});
                            state_next = B_EMIT;
                        end
                        KIND_COMBINE:
                        begin
                            mask_next  = q_item.mask;
                            sx_next    = '0;
                            sy_next    = '0;
                            cnt_next   = '0;
                            state_next = B_SUM;
                        end
                        default:
                        begin
                            dir_next   = DIR_NONE;
                            state_next = B_EMIT;
                        end
                    endcase
                end
            end
            B_SUM:
            begin
                if (mask_reg[cnt_reg[BTN_IDX_W-1:0]])
                begin
                    sx_next = sx_reg + SUM_W'(rd_entry.cx);
                    sy_next = sy_reg + SUM_W'(rd_entry.cy);
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SW'(BTN_W - 1))
                begin
                    state_next = B_PREP;
                end
            end
            B_PREP:
            begin
                cnt_next = '0;
                if (cancel)
                begin
                    dir_next   = DIR_NONE;
                    state_next = B_EMIT;
                end
                else
                begin
                    if (sx_reg[SUM_W-1])
                    begin
                        if (!sy_reg[SUM_W-1])
                        begin
                            x_next = sys;
                            y_next = -sxs;
                            z_next = ANG_90;
                        end
                        else
                        begin
                            x_next = -sys;
                            y_next = sxs;
                            z_next = -ANG_90;
                        end
                    end
                    else
                    begin
                        x_next = sxs;
                        y_next = sys;
                        z_next = '0;
                    end
                    state_next = B_VEC;
                end
            end
            B_VEC:
            begin
                if (!y_reg[VEC_W-1])
                begin
                    x_next = x_reg + sh_y;
                    y_next = y_reg - sh_x;
                    z_next = z_reg + atan_s;
                end
                else
                begin
                    x_next = x_reg - sh_y;
                    y_next = y_reg + sh_x;
                    z_next = z_reg - atan_s;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SW'(CORDIC_STAGES - 1))
                begin
                    state_next = B_WRAP;
                end
            end
            B_WRAP:
            begin
                if (z_reg[ANG_W-1])
                begin
                    z_next = z_wrap[ANG_W-1] ? '0 : z_wrap;
                end
                state_next = B_ROUND;
            end
            B_ROUND:
            begin
                dir_next   = signed'((deg_raw >= DEG_FULL) ? deg_raw - DEG_FULL : deg_raw);
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (dir_reg == last_reg)
                begin
                    state_next = B_IDLE;
                end
                else if (out_load)
                begin
                    last_next  = dir_reg;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            last_reg      <= DIR_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        dir_reg  <= dir_next;
        if (out_load)
        begin
            out_hat_reg <= hat;
            out_dir_reg <= dir_reg;
        end
    end

    assign empty      = !out_valid_reg;
    assign hat_select = out_hat_reg;
    assign direction  = out_dir_reg;

    `HDFB_ASSERT_IMP(a_dir_changes, clk, rst_n, out_load, dir_reg != last_reg)
    `HDFB_ASSERT_NXT(a_load_shows, clk, rst_n, out_load, out_valid_reg && (out_dir_reg == $past(dir_reg)))
    `HDFB_ASSERT_IMP(a_dir_range, clk, rst_n, out_valid_reg, (out_dir_reg == DIR_NONE) || (!out_dir_reg[DIR_W-1] && (out_dir_reg < 10'sd360)))
    `HDFB_ASSERT_IMP(a_vec_start_x, clk, rst_n, (state_reg == B_VEC) && (cnt_reg == '0), !x_reg[VEC_W-1])

endmodule

FILE: hdl/hat_direction_from_buttons_core.sv
// ---------------------------------------------------------------------------
// Hat direction from buttons core
// Turns direction button snapshots into a hat angle in whole degrees and
// reports it only when it changes.
// ---------------------------------------------------------------------------
// Channel   Handshake               Payload
// input     push / full             buttons
// result    empty / pop             hat_select, direction
// config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// An item with no press, one press or combining off goes straight to the emit state.
// A combined item passes through the unit vector sum over eight table
// entries and the vectoring CORDIC loop.
// After reset and after every write of input_count, the angle table builder
// holds full high while it builds min(input_count, 8) table entries
// with its serial divider and rotation CORDIC.
// A two-entry item queue and the result register let either side stall alone.
// ---------------------------------------------------------------------------
module hat_direction_from_buttons_core #(
    parameter int CORDIC_STAGES = hdfb_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [hdfb_pkg::BTN_W-1:0]           buttons,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [hdfb_pkg::HAT_W-1:0]           hat_select,
    output logic signed [hdfb_pkg::DIR_W-1:0]    direction,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hdfb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hdfb_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import hdfb_pkg::*;

    logic [CNT_W-1:0] input_count_reg, input_count_next;
    logic             combine_reg, combine_next;
    logic [HAT_W-1:0] hat_reg, hat_next;
    logic             cfg_write;
    logic             rebuild;
    cfg_t             cfg;
    logic             table_ready;
    logic             q_full;
    logic             q_empty;
    logic             q_write;
    logic             q_read;
    item_t            wr_item;
    item_t            rd_item;
    logic [BTN_IDX_W-1:0] rd_addr;
    entry_t           rd_entry;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign rebuild   = cfg_write && (cfg_index == REG_INPUT_COUNT);

    always_comb
    begin
        input_count_next = input_count_reg;
        combine_next     = combine_reg;
        hat_next         = hat_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_INPUT_COUNT:  input_count_next = cfg_data;
                REG_COMBINE_MODE: combine_next     = cfg_data[0];
                REG_HAT_INDEX:    hat_next         = cfg_data[HAT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_count_reg <= INPUT_COUNT_RST;
            combine_reg     <= 1'b1;
            hat_reg         <= '0;
        end
        else
        begin
            input_count_reg <= input_count_next;
            combine_reg     <= combine_next;
            hat_reg         <= hat_next;
        end
    end

    always_comb
    begin
        cfg.n_eff   = (input_count_reg > CNT_W'(N_CAP)) ? CNT_W'(N_CAP) : input_count_reg;
        cfg.combine = combine_reg;
    end

    hdfb_front u_front (
        .push        (push),
        .full        (full),
        .buttons     (buttons),
        .cfg         (cfg),
        .table_ready (table_ready),
        .q_full      (q_full),
        .q_write     (q_write),
        .q_item      (wr_item)
    );

    hdfb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .write   (q_write),
        .wr_item (wr_item),
        .q_full  (q_full),
        .read    (q_read),
        .rd_item (rd_item),
        .q_empty (q_empty)
    );

    hdfb_setup #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_setup (
        .clk         (clk),
        .rst_n       (rst_n),
        .rebuild     (rebuild),
        .n_eff       (cfg.n_eff),
        .table_ready (table_ready),
        .rd_addr     (rd_addr),
        .rd_entry    (rd_entry)
    );

    hdfb_back #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_item     (rd_item),
        .q_read     (q_read),
        .rd_addr    (rd_addr),
        .rd_entry   (rd_entry),
        .hat        (hat_reg),
        .empty      (empty),
        .pop        (pop),
        .hat_select (hat_select),
        .direction  (direction)
    );

endmodule
